@@ sv/vse_pkg.sv @@
// vse_pkg: shared constants, control word layout and microprogram for the
// visplane span extractor. No dependencies; used by every vse_* module.
`timescale 1ns / 1ps

package vse_pkg;

  // screen geometry and field widths
  localparam int ROWS   = 64;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CUR_W  = ROW_W + 1;   // row cursor, can hold ROWS itself
  localparam int X_W    = 9;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CUR_W-1:0] cur_t;
  typedef logic [X_W-1:0]   col_t;

  // microprogram step counter
  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE       = 3'd0;
  localparam step_t STEP_CLOSE_TOP  = 3'd1;
  localparam step_t STEP_CLOSE_BOT  = 3'd2;
  localparam step_t STEP_OPEN_TOP   = 3'd3;
  localparam step_t STEP_OPEN_BOT   = 3'd4;
  localparam step_t STEP_CHECK_LAST = 3'd5;
  localparam step_t STEP_FLUSH      = 3'd6;
  localparam step_t STEP_FINISH     = 3'd7;

  // branch condition selected by a control word
  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_CLOSE_TOP,
    COND_CLOSE_BOT,
    COND_OPEN_TOP,
    COND_OPEN_BOT,
    COND_LAST,
    COND_DRAINED
  } cond_t;

  // datapath action taken when the condition holds
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_EMIT_TOP,
    ACT_EMIT_BOT,
    ACT_WRITE_TOP,
    ACT_WRITE_BOT,
    ACT_ARM_FLUSH,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    cond_t cond;
    act_t  act;
    step_t next_t;   // target when condition holds
    step_t next_f;   // target when it does not
  } ucw_t;

  // strobes from sequencer to datapath and span queue
  typedef struct packed {
    logic load;
    logic emit_top;
    logic emit_bot;
    logic write_top;
    logic write_bot;
    logic arm_flush;
    logic finish;
  } ctrl_t;

  // loop conditions from datapath to sequencer
  typedef struct packed {
    logic close_top;
    logic close_bot;
    logic open_top;
    logic open_bot;
    logic last;
  } flags_t;

  // span queue status to sequencer
  typedef struct packed {
    logic emit_ok;
    logic drained;
  } qstat_t;

  // control store: one word per step
  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    unique case (s)
      STEP_IDLE:       w = '{COND_IN_VALID,  ACT_LOAD,      STEP_CLOSE_TOP,  STEP_IDLE};
      STEP_CLOSE_TOP:  w = '{COND_CLOSE_TOP, ACT_EMIT_TOP,  STEP_CLOSE_TOP,  STEP_CLOSE_BOT};
      STEP_CLOSE_BOT:  w = '{COND_CLOSE_BOT, ACT_EMIT_BOT,  STEP_CLOSE_BOT,  STEP_OPEN_TOP};
      STEP_OPEN_TOP:   w = '{COND_OPEN_TOP,  ACT_WRITE_TOP, STEP_OPEN_TOP,   STEP_OPEN_BOT};
      STEP_OPEN_BOT:   w = '{COND_OPEN_BOT,  ACT_WRITE_BOT, STEP_OPEN_BOT,   STEP_CHECK_LAST};
      STEP_CHECK_LAST: w = '{COND_LAST,      ACT_ARM_FLUSH, STEP_FLUSH,      STEP_FINISH};
      STEP_FLUSH:      w = '{COND_CLOSE_TOP, ACT_EMIT_TOP,  STEP_FLUSH,      STEP_FINISH};
      STEP_FINISH:     w = '{COND_DRAINED,   ACT_FINISH,    STEP_IDLE,       STEP_FINISH};
    endcase
    return w;
  endfunction

  // spare control word, never addressed by the program
  localparam ucw_t UCW_NOP = '{COND_ALWAYS, ACT_NONE, STEP_IDLE, STEP_IDLE};

endpackage

@@ sv/vse_sequencer.sv @@
// vse_sequencer: step counter and control store lookup; evaluates the branch
// condition of each word and raises at most one datapath strobe. Depends on vse_pkg.
`timescale 1ns / 1ps

module vse_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  vse_pkg::flags_t flags,
  input  vse_pkg::qstat_t qstat,
  output vse_pkg::ctrl_t  ctrl
);
  import vse_pkg::*;

  step_t pc;
  step_t pc_next;
  ucw_t  ucw;
  logic  cond_true;
  logic  needs_slot;
  logic  fire;

  // fetch and condition select
  always_comb begin
    ucw = ucode(pc);
    unique case (ucw.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_IN_VALID:  cond_true = in_valid;
      COND_CLOSE_TOP: cond_true = flags.close_top;
      COND_CLOSE_BOT: cond_true = flags.close_bot;
      COND_OPEN_TOP:  cond_true = flags.open_top;
      COND_OPEN_BOT:  cond_true = flags.open_bot;
      COND_LAST:      cond_true = flags.last;
      COND_DRAINED:   cond_true = qstat.drained;
      default:        cond_true = 1'b0;
    endcase
  end

  // emit words wait for a free slot in the span queue
  always_comb begin
    needs_slot = (ucw.act == ACT_EMIT_TOP) || (ucw.act == ACT_EMIT_BOT);
    fire       = cond_true && (!needs_slot || qstat.emit_ok);
    if (fire) begin
      pc_next = ucw.next_t;
    end else if (cond_true) begin
      pc_next = pc;
    end else begin
      pc_next = ucw.next_f;
    end
  end

  // action decode
  always_comb begin
    ctrl           = '0;
    ctrl.load      = fire && (ucw.act == ACT_LOAD);
    ctrl.emit_top  = fire && (ucw.act == ACT_EMIT_TOP);
    ctrl.emit_bot  = fire && (ucw.act == ACT_EMIT_BOT);
    ctrl.write_top = fire && (ucw.act == ACT_WRITE_TOP);
    ctrl.write_bot = fire && (ucw.act == ACT_WRITE_BOT);
    ctrl.arm_flush = fire && (ucw.act == ACT_ARM_FLUSH);
    ctrl.finish    = fire && (ucw.act == ACT_FINISH);
    in_ready       = (ucw.act == ACT_LOAD) && (ucw != UCW_NOP);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ sv/vse_datapath.sv @@
// vse_datapath: column range registers, row cursors, previous-column state and
// the per-row span start memory with registered read. Depends on vse_pkg.
`timescale 1ns / 1ps

module vse_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [8:0]           column_x,
  input  logic [5:0]           column_top,
  input  logic [5:0]           column_bottom,
  input  logic                 column_empty,
  input  logic                 first_column,
  input  logic                 last_column,
  input  vse_pkg::ctrl_t       ctrl,
  output vse_pkg::flags_t      flags,
  output vse_pkg::row_t        emit_row,
  output vse_pkg::col_t        emit_xend,
  output vse_pkg::col_t        rd_start
);
  import vse_pkg::*;

  // per-item working registers
  col_t x;
  col_t xend;
  cur_t t1;
  cur_t b1;
  cur_t t2;
  cur_t b2;
  cur_t ot;
  cur_t ob;
  logic last;

  // previous column range
  row_t prev_top;
  row_t prev_bottom;
  logic prev_empty;

  // span start store, undefined until written
  col_t span_start [ROWS];

  cur_t bot_c;
  logic new_empty;
  cur_t t2_in;
  cur_t b2_in;
  cur_t t1_in;
  cur_t b1_in;
  logic wr_en;
  row_t wr_addr;

  // clip and classify the incoming range
  always_comb begin
    if (int'(column_bottom) > ROWS - 1) begin
      bot_c = cur_t'(ROWS - 1);
    end else begin
      bot_c = cur_t'(column_bottom);
    end
    new_empty = column_empty || (int'(column_top) > int'(bot_c));
    t2_in     = new_empty ? cur_t'(ROWS) : cur_t'(column_top);
    b2_in     = new_empty ? '0 : bot_c;
    if (first_column || prev_empty) begin
      t1_in = cur_t'(ROWS);
      b1_in = '0;
    end else begin
      t1_in = cur_t'(prev_top);
      b1_in = cur_t'(prev_bottom);
    end
  end

  // loop conditions for the sequencer
  always_comb begin
    flags.close_top = (t1 < t2) && (t1 <= b1);
    flags.close_bot = (b1 > b2) && (b1 >= t1);
    flags.open_top  = (ot < t1) && (ot <= ob);
    flags.open_bot  = (ob > b1) && (ob >= ot);
    flags.last      = last;
    emit_row        = ctrl.emit_bot ? b1[ROW_W-1:0] : t1[ROW_W-1:0];
    emit_xend       = xend;
    wr_en           = ctrl.write_top || ctrl.write_bot;
    wr_addr         = ctrl.write_bot ? ob[ROW_W-1:0] : ot[ROW_W-1:0];
  end

  // working registers and cursors
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x    <= column_x;
      xend <= column_x - col_t'(1);
      t1   <= t1_in;
      b1   <= b1_in;
      t2   <= t2_in;
      b2   <= b2_in;
      ot   <= t2_in;
      ob   <= b2_in;
    end else if (ctrl.arm_flush) begin
      t1   <= t2;
      b1   <= b2;
      t2   <= cur_t'(ROWS);
      b2   <= '0;
      xend <= x;
    end else begin
      if (ctrl.emit_top) begin
        t1 <= t1 + cur_t'(1);
      end
      if (ctrl.emit_bot) begin
        b1 <= b1 - cur_t'(1);
      end
      if (ctrl.write_top) begin
        ot <= ot + cur_t'(1);
      end
      if (ctrl.write_bot) begin
        ob <= ob - cur_t'(1);
      end
    end
  end

  // previous column state, settled when the item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_top    <= '0;
      prev_bottom <= '0;
      prev_empty  <= 1'b1;
      last        <= 1'b0;
    end else if (ctrl.load) begin
      last        <= last_column;
      prev_empty  <= new_empty || last_column;
      prev_top    <= (new_empty || last_column) ? '0 : t2_in[ROW_W-1:0];
      prev_bottom <= (new_empty || last_column) ? '0 : b2_in[ROW_W-1:0];
    end
  end

  // span start memory: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      span_start[wr_addr] <= x;
    end
    if (ctrl.emit_top || ctrl.emit_bot) begin
      rd_start <= span_start[emit_row];
    end
  end

endmodule

@@ sv/vse_span_queue.sv @@
// vse_span_queue: read-align stage, one held span and the output register; the
// held span is released with last_of_run set at the end of an item. Uses vse_pkg.
`timescale 1ns / 1ps

module vse_span_queue (
  input  logic            clk,
  input  logic            rst,
  input  vse_pkg::ctrl_t  ctrl,
  input  vse_pkg::row_t   emit_row,
  input  vse_pkg::col_t   emit_xend,
  input  vse_pkg::col_t   rd_start,
  output vse_pkg::qstat_t qstat,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      span_row,
  output logic [8:0]      span_x_start,
  output logic [8:0]      span_x_end,
  output logic            last_of_run
);
  import vse_pkg::*;

  // stage a: span whose start is being read
  logic a_valid;
  row_t a_row;
  col_t a_xend;

  // held span, waiting to learn whether it is the last of the item
  logic p_valid;
  row_t p_row;
  col_t p_start;
  col_t p_end;

  logic emit;
  logic out_free;
  logic a_shift;
  logic o_mid;
  logic o_fin;

  // movement between stages
  always_comb begin
    emit          = ctrl.emit_top || ctrl.emit_bot;
    out_free      = !out_valid || out_ready;
    a_shift       = a_valid && (!p_valid || out_free);
    o_mid         = a_shift && p_valid;
    o_fin         = ctrl.finish && p_valid;
    qstat.emit_ok = !a_valid || a_shift;
    qstat.drained = !a_valid && (!p_valid || out_free);
  end

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        a_valid <= 1'b1;
      end else if (a_shift) begin
        a_valid <= 1'b0;
      end
      if (a_shift) begin
        p_valid <= 1'b1;
      end else if (ctrl.finish) begin
        p_valid <= 1'b0;
      end
      if (o_mid || o_fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit) begin
      a_row  <= emit_row;
      a_xend <= emit_xend;
    end
    if (a_shift) begin
      p_row   <= a_row;
      p_start <= rd_start;
      p_end   <= a_xend;
    end
    if (o_mid || o_fin) begin
      span_row     <= 6'(p_row);
      span_x_start <= p_start;
      span_x_end   <= p_end;
      last_of_run  <= o_fin;
    end
  end

  // a new span is only issued when stage a can move on
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    emit |-> qstat.emit_ok)
    else $error("span issued while read stage blocked");

  // item end only once the read stage is empty
  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish |-> !a_valid)
    else $error("item finished with a span still being read");

  // the held span leaves as the final beat of its item
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    (ctrl.finish && p_valid) |=> (out_valid && last_of_run && !p_valid))
    else $error("final span of item not marked");

  // an issue and a finish never coincide
  a_emit_finish: assert property (@(posedge clk) disable iff (rst)
    !(emit && ctrl.finish))
    else $error("emit and finish in one cycle");

endmodule

@@ sv/visplane_span_extractor.sv @@
// visplane_span_extractor: top level; joins the microcoded sequencer, the
// datapath with the span start memory and the output span queue. Uses vse_pkg.
`timescale 1ns / 1ps

// Takes one screen column of a floor or ceiling plane per input beat and
// returns the horizontal spans that the column closes, top-side rows first
// (downward), then bottom-side rows (upward); a column flagged last_column
// also flushes every row it leaves open, with span end equal to its own x.
// last_of_run marks the final span of each column. A column passes the idle,
// close-top, close-bottom, open-top, open-bottom, check-last and finish steps (and
// the extra flush step for a column flagged last_column); each span closed, row
// newly opened and row flushed is one step of the microprogram, one access to
// the single-port span start memory. A waiting consumer stalls span issue
// once the read stage, the one-span hold stage and the output register are
// all full. The span start memory needs no clearing after reset.
module visplane_span_extractor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] column_x,
  input  logic [5:0] column_top,
  input  logic [5:0] column_bottom,
  input  logic       column_empty,
  input  logic       first_column,
  input  logic       last_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] span_row,
  output logic [8:0] span_x_start,
  output logic [8:0] span_x_end,
  output logic       last_of_run
);
  import vse_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  qstat_t qstat;
  row_t   emit_row;
  col_t   emit_xend;
  col_t   rd_start;

  // control program
  vse_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .qstat    (qstat),
    .ctrl     (ctrl)
  );

  // range registers and span start memory
  vse_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .column_x      (column_x),
    .column_top    (column_top),
    .column_bottom (column_bottom),
    .column_empty  (column_empty),
    .first_column  (first_column),
    .last_column   (last_column),
    .ctrl          (ctrl),
    .flags         (flags),
    .emit_row      (emit_row),
    .emit_xend     (emit_xend),
    .rd_start      (rd_start)
  );

  // span output
  vse_span_queue u_q (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .emit_row     (emit_row),
    .emit_xend    (emit_xend),
    .rd_start     (rd_start),
    .qstat        (qstat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_row     (span_row),
    .span_x_start (span_x_start),
    .span_x_end   (span_x_end),
    .last_of_run  (last_of_run)
  );

endmodule

@@ verif/tb_visplane_span_extractor.sv @@
// tb_visplane_span_extractor: self-checking testbench for the visplane span extractor.
// Drives screen columns, predicts the finished spans in a local model of the row
// state, and checks every output beat in order. Depends on vse_pkg and the top level.
`timescale 1ns / 1ps

module tb_visplane_span_extractor;
  import vse_pkg::*;

  localparam int SCREEN_COLUMNS = 320;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 200;

  typedef struct {
    logic [5:0] row;
    logic [8:0] x_start;
    logic [8:0] x_end;
    logic       last;
  } span_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [8:0] column_x;
  logic [5:0] column_top;
  logic [5:0] column_bottom;
  logic       column_empty;
  logic       first_column;
  logic       last_column;
  logic       out_valid;
  logic       out_ready;
  logic [5:0] span_row;
  logic [8:0] span_x_start;
  logic [8:0] span_x_end;
  logic       last_of_run;

  // predicted row state
  logic [8:0] row_start [ROWS];
  int         open_top;
  int         open_bot;
  bit         open_none;

  span_t      column_spans [$];
  span_t      pending_spans [$];

  bit         idle_on;
  int         hold_off_left;
  int         columns_sent;
  int         error_count;
  int         cycle_count;

  visplane_span_extractor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .column_x     (column_x),
    .column_top   (column_top),
    .column_bottom(column_bottom),
    .column_empty (column_empty),
    .first_column (first_column),
    .last_column  (last_column),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .span_row     (span_row),
    .span_x_start (span_x_start),
    .span_x_end   (span_x_end),
    .last_of_run  (last_of_run)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // span prediction

  function automatic void add_span(input int row, input logic [8:0] xend);
    span_t s;
    if (column_spans.size() >= 64) return;
    s.row     = row[5:0];
    s.x_start = row_start[row];
    s.x_end   = xend;
    s.last    = 1'b0;
    column_spans.push_back(s);
  endfunction

  // close rows of the old range that fall outside the new one
  function automatic void close_rows_outside(inout int t1, inout int b1, input int t2,
                                             input int b2, input logic [8:0] xend);
    while (t1 < t2 && t1 <= b1) begin
      add_span(t1, xend);
      t1++;
    end
    while (b1 > b2 && b1 >= t1) begin
      add_span(b1, xend);
      b1--;
    end
  endfunction

  function automatic void extract_spans(input logic [8:0] x, input logic [5:0] top,
                                        input logic [5:0] bot, input logic empty,
                                        input logic first, input logic last);
    int t1, b1, t2, b2, ot, ob, bclip;
    logic [8:0] xprev;
    column_spans.delete();
    xprev = x - 9'd1;
    bclip = int'(bot);
    if (bclip > ROWS - 1) bclip = ROWS - 1;
    // inverted range counts as an empty column
    if (empty || int'(top) > bclip) begin
      t2 = ROWS;
      b2 = 0;
    end else begin
      t2 = int'(top);
      b2 = bclip;
    end
    if (first || open_none) begin
      t1 = ROWS;
      b1 = 0;
    end else begin
      t1 = open_top;
      b1 = open_bot;
    end
    close_rows_outside(t1, b1, t2, b2, xprev);
    // rows entering the range take this column as start
    ot = t2;
    ob = b2;
    while (ot < t1 && ot <= ob) begin
      row_start[ot] = x;
      ot++;
    end
    while (ob > b1 && ob >= ot) begin
      row_start[ob] = x;
      ob--;
    end
    open_none = (t2 > b2);
    open_top  = open_none ? 0 : t2;
    open_bot  = open_none ? 0 : b2;
    // implicit empty column after the last one
    if (last) begin
      t1 = t2;
      b1 = b2;
      close_rows_outside(t1, b1, ROWS, 0, x);
      open_none = 1'b1;
      open_top  = 0;
      open_bot  = 0;
    end
    if (column_spans.size() > 0) column_spans[column_spans.size() - 1].last = 1'b1;
    foreach (column_spans[i]) pending_spans.push_back(column_spans[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // input side

  task automatic send_column(input logic [8:0] x, input logic [5:0] top,
                             input logic [5:0] bot, input logic empty,
                             input logic first, input logic last);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid      = 1'b1;
    column_x      = x;
    column_top    = top;
    column_bottom = bot;
    column_empty  = empty;
    first_column  = first;
    last_column   = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    extract_spans(x, top, bot, empty, first, last);
    columns_sent++;
  endtask

  function automatic int clamp_row(input int r);
    if (r < 0) return 0;
    if (r > ROWS - 1) return ROWS - 1;
    return r;
  endfunction

  // one plane of consecutive columns with a drifting open range
  task automatic send_plane(input int len, input bit close_plane);
    logic [8:0] x;
    int top, bot, pick, tt, bb;
    bit empty;
    x = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                     : 9'($urandom_range(0, SCREEN_COLUMNS - 1));
    top = $urandom_range(0, 50);
    bot = clamp_row(top + $urandom_range(0, 12));
    for (int i = 0; i < len; i++) begin
      pick  = $urandom_range(0, 15);
      empty = 1'b0;
      tt    = top;
      bb    = bot;
      if (pick == 0) begin
        empty = 1'b1;
        tt    = $urandom_range(0, 63);
        bb    = $urandom_range(0, 63);
      end else if (pick == 1) begin
        tt = $urandom_range(1, 63);
        bb = $urandom_range(0, tt - 1);
      end else begin
        if (pick == 2) begin
          top = $urandom_range(0, 63);
          bot = $urandom_range(top, 63);
        end else begin
          top = clamp_row(top + $urandom_range(0, 6) - 3);
          bot = clamp_row(bot + $urandom_range(0, 6) - 3);
          if (bot < top) bot = top;
        end
        tt = top;
        bb = bot;
      end
      send_column(x, tt[5:0], bb[5:0], empty, i == 0, close_plane && i == len - 1);
      x = x + 9'd1;
    end
  endtask

  task automatic send_noise_column;
    send_column(9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
                6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // output side

  // receiver ready: random short stalls, plus a long hold-off on request
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare every accepted span beat with the oldest prediction
  always @(posedge clk) begin : check_span
    span_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("unexpected span, row", span_row, -1);
      end else begin
        want = pending_spans.pop_front();
        if (span_row !== want.row) report_mismatch("span_row", span_row, want.row);
        if (span_x_start !== want.x_start)
          report_mismatch("span_x_start", span_x_start, want.x_start);
        if (span_x_end !== want.x_end) report_mismatch("span_x_end", span_x_end, want.x_end);
        if (last_of_run !== want.last) report_mismatch("last_of_run", last_of_run, want.last);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests

  task automatic test_directed_cases;
    // single column, full height, flushed at column zero
    send_column(9'd0, 6'd0, 6'd63, 1'b0, 1'b1, 1'b1);
    // narrowing, widening, inverted, empty flag, one row, full flush
    send_column(9'd0, 6'd10, 6'd20, 1'b0, 1'b1, 1'b0);
    send_column(9'd1, 6'd12, 6'd18, 1'b0, 1'b0, 1'b0);
    send_column(9'd2, 6'd5, 6'd25, 1'b0, 1'b0, 1'b0);
    send_column(9'd3, 6'd30, 6'd5, 1'b0, 1'b0, 1'b0);
    send_column(9'd4, 6'd63, 6'd0, 1'b1, 1'b0, 1'b0);
    send_column(9'd5, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0);
    send_column(9'd6, 6'd0, 6'd63, 1'b0, 1'b0, 1'b0);
    send_column(9'd7, 6'd40, 6'd41, 1'b0, 1'b0, 1'b1);
    // span closed at column zero wraps its end to 511
    send_column(9'd511, 6'd3, 6'd60, 1'b0, 1'b1, 1'b0);
    send_column(9'd0, 6'd4, 6'd59, 1'b0, 1'b0, 1'b1);
    // unfinished plane dropped by the next first column
    send_column(9'd100, 6'd0, 6'd40, 1'b0, 1'b1, 1'b0);
    send_column(9'd101, 6'd2, 6'd30, 1'b0, 1'b0, 1'b0);
    send_column(9'd200, 6'd20, 6'd50, 1'b0, 1'b1, 1'b0);
    send_column(9'd201, 6'd21, 6'd49, 1'b1, 1'b0, 1'b1);
    // disjoint ranges and columns past the screen edge
    send_column(9'd318, 6'd0, 6'd9, 1'b0, 1'b1, 1'b0);
    send_column(9'd319, 6'd50, 6'd63, 1'b0, 1'b0, 1'b0);
    send_column(9'd320, 6'd0, 6'd9, 1'b0, 1'b0, 1'b0);
    send_column(9'd321, 6'd8, 6'd52, 1'b0, 1'b0, 1'b1);
    // last column that is empty, then a lone empty plane
    send_column(9'd400, 6'd1, 6'd2, 1'b0, 1'b1, 1'b0);
    send_column(9'd401, 6'd0, 6'd0, 1'b1, 1'b0, 1'b1);
    send_column(9'd42, 6'd21, 6'd42, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic test_random_planes;
    int len;
    while (columns_sent < 320) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise_column();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
        send_plane(len, $urandom_range(0, 7) != 0);
      end
    end
  endtask

  // receiver holds off long enough for the input side to stall
  task automatic test_output_hold_off;
    hold_off_left = 400;
    send_plane(12, 1'b1);
    send_plane(6, 1'b1);
  endtask

  task automatic test_steady_stream;
    idle_on = 1'b0;
    while (columns_sent < 380) send_plane($urandom_range(1, 8), 1'b1);
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    column_x      = '0;
    column_top    = '0;
    column_bottom = '0;
    column_empty  = 1'b0;
    first_column  = 1'b0;
    last_column   = 1'b0;
    idle_on       = 1'b1;
    hold_off_left = 0;
    columns_sent  = 0;
    error_count   = 0;
    open_top      = 0;
    open_bot      = 0;
    open_none     = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_random_planes();
    test_output_hold_off();
    test_steady_stream();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/vse_pkg.sv
sv/vse_sequencer.sv
sv/vse_datapath.sv
sv/vse_span_queue.sv
sv/visplane_span_extractor.sv
verif/tb_visplane_span_extractor.sv
